// ===== rtl/ple_pkg.sv =====
// Shared types, codes and sizes for the positional list engine.
`default_nettype none
package ple_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OP_W = 3;
   localparam int DATA_W = 32;
   localparam int POS_W = 8;
   localparam int STAT_W = 3;
   localparam int LEN_W = 5;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
   localparam logic [OP_W-1:0] OP_READ_OUT  = 3'd6;

   localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
   localparam logic [STAT_W-1:0] ST_APPEND = 3'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
   localparam logic [STAT_W-1:0] ST_RANGE  = 3'd4;

   typedef enum logic [1:0] {
      K_NONE,
      K_INS,
      K_DEL,
      K_READ
   } kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_PUT,
      S_READ
   } state_type;

   // Work plan for one command, worked out when the command is taken.
   typedef struct packed {
      kind_type              kind;
      logic [STAT_W-1:0]     status;
      logic [IDX_W-1:0]      idx;
      logic [CNT_W-1:0]      moves;
      logic [CNT_W-1:0]      new_count;
   } plan_type;

endpackage
`default_nettype wire

// ===== rtl/ple_plan.sv =====
// Command decode: status, target slot and shift length for one command.
`default_nettype none
module ple_plan (
   input  wire logic [ple_pkg::OP_W-1:0]  opcode,
   input  wire logic [ple_pkg::POS_W-1:0] position,
   input  wire logic [ple_pkg::CNT_W-1:0] count,
   output ple_pkg::plan_type              plan
);

   localparam int WIDE_W = ple_pkg::CNT_W + ple_pkg::POS_W;

   logic [WIDE_W-1:0]         pos_x;
   logic [WIDE_W-1:0]         cnt_x;
   logic [WIDE_W-1:0]         pos_m1;
   logic [ple_pkg::CNT_W-1:0] idx_c;

   assign pos_x  = WIDE_W'(position);
   assign cnt_x  = WIDE_W'(count);
   assign pos_m1 = pos_x - WIDE_W'(1);

   always_comb begin
      idx_c          = '0;
      plan.kind      = ple_pkg::K_NONE;
      plan.status    = ple_pkg::ST_OK;
      plan.moves     = '0;
      plan.new_count = count;
      case (opcode)
         ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_POS: begin
            if (count >= ple_pkg::CNT_W'(ple_pkg::DEPTH)) begin
               plan.status = ple_pkg::ST_FULL;
            end else begin
               plan.kind      = ple_pkg::K_INS;
               plan.new_count = count + ple_pkg::CNT_W'(1);
               if (opcode == ple_pkg::OP_INS_FRONT || count == '0 ||
                   (opcode == ple_pkg::OP_INS_POS && pos_x <= WIDE_W'(1))) begin
                  idx_c = '0;
               end else if (opcode == ple_pkg::OP_INS_BACK) begin
                  idx_c = count;
               end else if (pos_x >= cnt_x + WIDE_W'(1)) begin
                  idx_c       = count;
                  plan.status = ple_pkg::ST_APPEND;
               end else begin
                  idx_c = pos_m1[ple_pkg::CNT_W-1:0];
               end
               plan.moves = count - idx_c;
            end
         end
         ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
            if (count == '0) begin
               plan.status = ple_pkg::ST_EMPTY;
            end else begin
               plan.kind      = ple_pkg::K_DEL;
               plan.new_count = count - ple_pkg::CNT_W'(1);
               idx_c = (opcode == ple_pkg::OP_DEL_FRONT) ? '0 : count - ple_pkg::CNT_W'(1);
               plan.moves = count - ple_pkg::CNT_W'(1) - idx_c;
            end
         end
         ple_pkg::OP_DEL_POS: begin
            if (count == '0) begin
               plan.status = ple_pkg::ST_EMPTY;
            end else if (pos_x < WIDE_W'(1) || pos_x > cnt_x) begin
               plan.status = ple_pkg::ST_RANGE;
            end else begin
               plan.kind      = ple_pkg::K_DEL;
               plan.new_count = count - ple_pkg::CNT_W'(1);
               idx_c          = pos_m1[ple_pkg::CNT_W-1:0];
               plan.moves     = count - ple_pkg::CNT_W'(1) - idx_c;
            end
         end
         ple_pkg::OP_READ_OUT: begin
            if (count == '0) begin
               plan.status = ple_pkg::ST_EMPTY;
            end else begin
               plan.kind  = ple_pkg::K_READ;
               plan.moves = count;
            end
         end
         default: begin
            plan.status = ple_pkg::ST_OK;
         end
      endcase
      plan.idx = idx_c[ple_pkg::IDX_W-1:0];
   end

endmodule
`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
// Top level of the positional list engine: slot memory, shift sequencer, result register.
`default_nettype none
// An ordered list of up to 16 signed 32-bit words lives in a slot memory, front at
// slot 0. A command is taken when start is high and busy is low; busy stays high until
// the command's last result has been registered. Inserts and deletes walk the slot
// memory one word per cycle through a single read port and a single write port.
// Read out streams one word per cycle from the registered read port. Commands that
// move nothing (full, empty, out of range, unused opcode) answer in the cycle after
// they are taken. Each result shows on the rsp_ ports for exactly one cycle under
// rsp_valid; the receiver cannot stall it, so capture every strobe. rsp_last marks
// the final result of a command.
module positional_list_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [ple_pkg::OP_W-1:0]      req_opcode,
   input  wire logic signed [ple_pkg::DATA_W-1:0] req_value,
   input  wire logic [ple_pkg::POS_W-1:0]     req_position,
   output logic                               rsp_valid,
   output logic [ple_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [ple_pkg::DATA_W-1:0]  rsp_element,
   output logic [ple_pkg::LEN_W-1:0]          rsp_length,
   output logic                               rsp_last
);

   ple_pkg::state_type          state_ff, state_in;
   ple_pkg::plan_type           plan;
   ple_pkg::plan_type           plan_ff, plan_in;
   logic [ple_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [ple_pkg::CNT_W-1:0]   moves_ff, moves_in;
   logic [ple_pkg::IDX_W-1:0]   dst_ff, dst_in;
   logic [ple_pkg::IDX_W-1:0]   pend_dst_ff, pend_dst_in;
   logic                        pend_ff, pend_in;
   logic                        pend_last_ff, pend_last_in;
   logic [ple_pkg::DATA_W-1:0]  value_ff, value_in;
   logic [ple_pkg::DATA_W-1:0]  rd_data_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ple_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ple_pkg::DATA_W-1:0]  rsp_element_ff, rsp_element_in;
   logic [ple_pkg::LEN_W-1:0]   rsp_length_ff, rsp_length_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [ple_pkg::DATA_W-1:0]  slot_mem [ple_pkg::DEPTH];
   logic                        mem_we;
   logic [ple_pkg::IDX_W-1:0]   mem_waddr;
   logic [ple_pkg::IDX_W-1:0]   mem_raddr;
   logic [ple_pkg::DATA_W-1:0]  mem_wdata;

   logic accept;
   logic issue;
   logic is_ins;

   assign busy   = (state_ff != ple_pkg::S_IDLE);
   assign accept = start && !busy;
   assign issue  = (moves_ff != '0);
   assign is_ins = (plan_ff.kind == ple_pkg::K_INS);

   // Decode the incoming command against the current length.
   ple_plan u_plan (
      .opcode   (req_opcode),
      .position (req_position),
      .count    (count_ff),
      .plan     (plan)
   );

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[mem_raddr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ple_pkg::S_IDLE: begin
            if (accept) begin
               case (plan.kind)
                  ple_pkg::K_INS, ple_pkg::K_DEL: state_in = ple_pkg::S_SHIFT;
                  ple_pkg::K_READ:                state_in = ple_pkg::S_READ;
                  default:                        state_in = ple_pkg::S_IDLE;
               endcase
            end
         end
         ple_pkg::S_SHIFT: begin
            // Shift is over once nothing is left to issue and the last word is written.
            if (!issue && !pend_ff) begin
               state_in = is_ins ? ple_pkg::S_PUT : ple_pkg::S_IDLE;
            end
         end
         ple_pkg::S_PUT: begin
            state_in = ple_pkg::S_IDLE;
         end
         ple_pkg::S_READ: begin
            if (!issue && !pend_ff) begin
               state_in = ple_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ple_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      plan_in        = plan_ff;
      value_in       = value_ff;
      count_in       = count_ff;
      moves_in       = moves_ff;
      dst_in         = dst_ff;
      pend_in        = 1'b0;
      pend_last_in   = 1'b0;
      pend_dst_in    = pend_dst_ff;
      mem_we         = 1'b0;
      mem_waddr      = pend_dst_ff;
      mem_wdata      = rd_data_ff;
      mem_raddr      = dst_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = ple_pkg::ST_OK;
      rsp_element_in = '0;
      rsp_length_in  = ple_pkg::LEN_W'(count_ff);
      rsp_last_in    = 1'b0;
      case (state_ff)
         ple_pkg::S_IDLE: begin
            if (accept) begin
               plan_in  = plan;
               value_in = req_value;
               moves_in = plan.moves;
               // Insert walks down from the first free slot; others start at the target.
               dst_in   = (plan.kind == ple_pkg::K_INS) ? count_ff[ple_pkg::IDX_W-1:0]
                                                        : plan.idx;
               if (plan.kind == ple_pkg::K_NONE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = plan.status;
                  rsp_last_in   = 1'b1;
               end
            end
         end
         ple_pkg::S_SHIFT: begin
            // Read the neighbor word, write it one slot over in the next cycle.
            mem_raddr = is_ins ? dst_ff - ple_pkg::IDX_W'(1) : dst_ff + ple_pkg::IDX_W'(1);
            mem_we    = pend_ff;
            if (issue) begin
               pend_in     = 1'b1;
               pend_dst_in = dst_ff;
               dst_in      = is_ins ? dst_ff - ple_pkg::IDX_W'(1) : dst_ff + ple_pkg::IDX_W'(1);
               moves_in    = moves_ff - ple_pkg::CNT_W'(1);
            end
            if (!issue && !pend_ff && !is_ins) begin
               count_in      = plan_ff.new_count;
               rsp_valid_in  = 1'b1;
               rsp_status_in = plan_ff.status;
               rsp_length_in = ple_pkg::LEN_W'(plan_ff.new_count);
               rsp_last_in   = 1'b1;
            end
         end
         ple_pkg::S_PUT: begin
            // Drop the new word into the opened slot.
            mem_we        = 1'b1;
            mem_waddr     = plan_ff.idx;
            mem_wdata     = value_ff;
            count_in      = plan_ff.new_count;
            rsp_valid_in  = 1'b1;
            rsp_status_in = plan_ff.status;
            rsp_length_in = ple_pkg::LEN_W'(plan_ff.new_count);
            rsp_last_in   = 1'b1;
         end
         ple_pkg::S_READ: begin
            if (issue) begin
               pend_in      = 1'b1;
               pend_last_in = (moves_ff == ple_pkg::CNT_W'(1));
               dst_in       = dst_ff + ple_pkg::IDX_W'(1);
               moves_in     = moves_ff - ple_pkg::CNT_W'(1);
            end
            if (pend_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_element_in = rd_data_ff;
               rsp_last_in    = pend_last_ff;
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ple_pkg::S_IDLE;
         count_ff     <= '0;
         moves_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         moves_ff     <= moves_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      plan_ff        <= plan_in;
      value_ff       <= value_in;
      dst_ff         <= dst_in;
      pend_dst_ff    <= pend_dst_in;
      pend_last_ff   <= pend_last_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_length  = rsp_length_ff;
   assign rsp_last    = rsp_last_ff;

   // The list never grows past its capacity.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
      else $error("list length beyond capacity");

   // A word still in flight from memory belongs to a shift or a read out.
   a_pend_owner: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ple_pkg::S_SHIFT || state_ff == ple_pkg::S_READ))
      else $error("memory word pending outside a walk");

   // A result that is not final only shows while the command is still running.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("intermediate result after command end");

   // Every non-ok status closes its command.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ple_pkg::ST_OK) |-> rsp_last)
      else $error("error status on a non-final result");

endmodule
`default_nettype wire

// ===== tb/list_check_pkg.sv =====
// Result predictor and checker class for the positional list engine testbench.
package list_check_pkg;
   import ple_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] element;
      logic [LEN_W-1:0]         length;
      logic                     last;
   } list_result_type;

   class list_checker;
      logic signed [DATA_W-1:0] slots [DEPTH];
      int                       count;
      int                       errors;
      list_result_type          awaited [$];

      function new();
         count = 0;
         errors = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Print one line per mismatch and count it.
      task report(string what);
         $display("%0t mismatch: %s", $time, what);
         errors++;
      endtask

      function void queue_result(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] el,
                                 logic lst);
         list_result_type r;
         r.status = st;
         r.element = el;
         r.length = LEN_W'(count);
         r.last = lst;
         awaited.push_back(r);
      endfunction

      // Open a hole at idx by moving the tail back one slot.
      function void insert_word(int idx, logic signed [DATA_W-1:0] val);
         for (int i = count; i > idx; i--) begin
            slots[i] = slots[i-1];
         end
         slots[idx] = val;
         count++;
      endfunction

      // Close the hole at idx by moving the tail forward one slot.
      function void remove_word(int idx);
         for (int i = idx; i + 1 < count; i++) begin
            slots[i] = slots[i+1];
         end
         count--;
      endfunction

      // Apply one accepted command word to the shadow list and queue its results.
      function void note_command(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                                 logic [POS_W-1:0] pos);
         logic [STAT_W-1:0] st;
         bit                streamed;
         st = ST_OK;
         streamed = 0;
         case (op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
               if (count >= DEPTH) begin
                  st = ST_FULL;
               end else if (op == OP_INS_FRONT || count == 0 ||
                            (op == OP_INS_POS && pos <= 1)) begin
                  insert_word(0, val);
               end else if (op == OP_INS_BACK) begin
                  insert_word(count, val);
               end else if (int'(pos) >= count + 1) begin
                  insert_word(count, val);
                  st = ST_APPEND;
               end else begin
                  insert_word(int'(pos) - 1, val);
               end
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
               if (count == 0) begin
                  st = ST_EMPTY;
               end else begin
                  remove_word(op == OP_DEL_FRONT ? 0 : count - 1);
               end
            end
            OP_DEL_POS: begin
               if (count == 0) begin
                  st = ST_EMPTY;
               end else if (pos < 1 || int'(pos) > count) begin
                  st = ST_RANGE;
               end else begin
                  remove_word(int'(pos) - 1);
               end
            end
            OP_READ_OUT: begin
               if (count == 0) begin
                  st = ST_EMPTY;
               end else begin
                  for (int i = 0; i < count; i++) begin
                     queue_result(ST_OK, slots[i], i + 1 == count);
                  end
                  streamed = 1;
               end
            end
            default: ;
         endcase
         if (!streamed) begin
            queue_result(st, '0, 1'b1);
         end
      endfunction

      // Compare one strobed result with the oldest queued expectation.
      task check_result(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] el,
                        logic [LEN_W-1:0] len, logic lst);
         list_result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("result with nothing queued (status %0d element %0d)",
                             st, el));
            return;
         end
         want = awaited.pop_front();
         if (st !== want.status) begin
            report($sformatf("status got %0d want %0d", st, want.status));
         end
         if (el !== want.element) begin
            report($sformatf("element got %0d want %0d", el, want.element));
         end
         if (len !== want.length) begin
            report($sformatf("length got %0d want %0d", len, want.length));
         end
         if (lst !== want.last) begin
            report($sformatf("last got %b want %b", lst, want.last));
         end
      endtask
   endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench for the positional list engine: stimulus, response capture, verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ple_pkg::*;
   import list_check_pkg::*;

   // The opcode field has one code that no operation uses.
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   // Generous bound for a few hundred command words.
   localparam int CYCLE_LIMIT = 200000;
   // Quiet time after the last result, longer than a full read out.
   localparam int SETTLE_CYCLES = 40;

   typedef enum int {
      MOOD_GROW,
      MOOD_MIXED,
      MOOD_SHRINK
   } mood_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [OP_W-1:0]          req_opcode = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_valid;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0] rsp_element;
   logic [LEN_W-1:0]         rsp_length;
   logic                     rsp_last;

   list_checker chk = new();
   int          idle_pct = 0;

   positional_list_engine uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_element(rsp_element),
      .rsp_length(rsp_length),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Capture every result strobe; the block cannot be stalled, so never skip one.
   // Values read here at the edge are the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         chk.check_result(rsp_status, rsp_element, rsp_length, rsp_last);
      end
   end

   // Present one command word and hold it until the block takes it. Each cycle the
   // sender idles with the current percentage and drops start; the word is taken at
   // the first edge with start high and busy low.
   task automatic send_word(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
                            input logic [POS_W-1:0] pos);
      bit offer;
      req_opcode <= op;
      req_value <= val;
      req_position <= pos;
      do begin
         offer = ($urandom_range(99) >= idle_pct);
         start <= offer;
         @(posedge clock);
      end while (!(offer && !busy));
      chk.note_command(op, val, pos);
   endtask

   // Drop start and hold off until every queued result has come back.
   task automatic drain_list();
      start <= 1'b0;
      while (chk.pending() != 0) @(posedge clock);
   endtask

   // Lean on the sign bit, all ones and all zeros, otherwise any pattern.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Aim positions at the list's edges: below 1, the front, the back, one past it.
   function automatic logic [POS_W-1:0] pick_position();
      int c;
      c = chk.count;
      case ($urandom_range(5))
         0: return '0;
         1: return POS_W'(1);
         2: return POS_W'(c);
         3: return POS_W'(c + 1);
         4: return POS_W'($urandom_range(c + 1));
         default: return POS_W'($urandom_range(255));
      endcase
   endfunction

   // Pick a random command whose mix depends on whether the list should grow or shrink.
   task automatic random_word(input mood_type mood);
      int              r;
      int              ins_cut;
      int              del_cut;
      logic [OP_W-1:0] op;
      r = $urandom_range(99);
      ins_cut = (mood == MOOD_GROW) ? 78 : (mood == MOOD_MIXED) ? 42 : 14;
      del_cut = (mood == MOOD_GROW) ? 88 : 85;
      if (r < ins_cut) begin
         case ($urandom_range(2))
            0: op = OP_INS_FRONT;
            1: op = OP_INS_BACK;
            default: op = OP_INS_POS;
         endcase
      end else if (r < del_cut) begin
         case ($urandom_range(2))
            0: op = OP_DEL_FRONT;
            1: op = OP_DEL_BACK;
            default: op = OP_DEL_POS;
         endcase
      end else if (r < 97) begin
         op = OP_READ_OUT;
      end else begin
         op = OP_UNUSED;
      end
      send_word(op, pick_value(), pick_position());
   endtask

   // One stretch of random traffic at a given sender idle rate, ending in a full drain.
   // The first stretch opens with a fill to capacity, inserts into the full list and
   // a full-length read out, so the full list is always reached.
   task automatic run_phase(input int pct, input int words, input bit fill_first);
      int sent;
      sent = 0;
      idle_pct = pct;
      if (fill_first) begin
         while (chk.count < DEPTH) begin
            random_word(MOOD_GROW);
            sent++;
         end
         send_word(OP_INS_FRONT, pick_value(), pick_position());
         send_word(OP_INS_BACK, pick_value(), pick_position());
         send_word(OP_INS_POS, pick_value(), pick_position());
         send_word(OP_READ_OUT, pick_value(), pick_position());
         sent += 4;
      end
      while (sent < words) begin
         random_word(mood_type'((sent / 24) % 3));
         sent++;
      end
      drain_list();
   endtask

   // Stop the run if it hangs.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      // Hold reset, then release it once.
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 19;
      // Every read and delete command, and the unused code, against an empty list.
      send_word(OP_READ_OUT, 32'h1234_5678, 8'd1);
      send_word(OP_DEL_FRONT, '0, 8'd0);
      send_word(OP_DEL_BACK, '0, 8'd0);
      send_word(OP_DEL_POS, '0, 8'd1);
      send_word(OP_UNUSED, '1, 8'hFF);
      // Positional insert into an empty list lands as the only element.
      send_word(OP_INS_POS, 32'h0BAD_F00D, 8'd200);
      // Delete of the only element.
      send_word(OP_DEL_POS, '0, 8'd1);
      // Build a short list with extreme values and every insert flavor.
      send_word(OP_INS_BACK, 32'h8000_0000, 8'd0);
      send_word(OP_INS_FRONT, 32'h7FFF_FFFF, 8'd0);
      send_word(OP_INS_POS, -32'sd1, 8'd0);
      send_word(OP_INS_POS, '0, 8'd1);
      send_word(OP_INS_POS, 32'h5555_5555, 8'd255);
      send_word(OP_INS_POS, 32'hAAAA_AAAA, 8'd6);
      send_word(OP_INS_POS, 32'sd123, 8'd3);
      // Out-of-range deletes leave the list alone.
      send_word(OP_DEL_POS, '0, 8'd0);
      send_word(OP_DEL_POS, '0, 8'd8);
      send_word(OP_DEL_POS, '0, 8'd255);
      // Valid deletes at the back position, in the middle, and at both ends.
      send_word(OP_DEL_POS, '0, 8'd7);
      send_word(OP_DEL_POS, '0, 8'd2);
      send_word(OP_DEL_FRONT, '0, 8'd0);
      send_word(OP_DEL_BACK, '0, 8'd0);
      send_word(OP_READ_OUT, '0, 8'd0);
      send_word(OP_UNUSED, 32'h0F0F_0F0F, 8'd3);
      drain_list();

      // Sender idles often at first, then more often... then never.
      run_phase(19, 67, 1'b1);
      run_phase(52, 67, 1'b0);
      run_phase(0, 67, 1'b0);

      // Let any stray strobe show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (chk.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
